// ===== rtl/rdse_pkg.sv =====
// Shared types, constants and the digit-to-character mapping of the radix digit string emitter.
package rdse_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W = 7;
    localparam int KIND_W = 2;
    localparam int DIV_STEP = 4;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'd65;

    typedef enum logic [KIND_W-1:0] {
        CMD_CONVERT,
        CMD_ZERO,
        CMD_INVALID
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic pop_cmd;
        logic load;
        logic div_run;
        logic wr_en;
        logic rd_issue;
        logic spec_issue;
    } back_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DECIMAL_LIMIT)
        begin
            c = CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT) + CHAR_LETTER_A;
        end
        else
        begin
            c = CHAR_W'(d) + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ===== rtl/rdse_front.sv =====
// Front part: sorts each incoming beat into invalid base, zero or conversion.
module rdse_front #(
    parameter int VALUE_BITS = 31
) (
    input  logic [VALUE_BITS-1:0]           value,
    input  logic [rdse_pkg::RADIX_W-1:0]    radix,
    output rdse_pkg::cmd_kind_t             kind
);

    always_comb
    begin
        if ((radix < rdse_pkg::RADIX_MIN) || (radix > rdse_pkg::RADIX_MAX))
        begin
            kind = rdse_pkg::CMD_INVALID;
        end
        else if (value == '0)
        begin
            kind = rdse_pkg::CMD_ZERO;
        end
        else
        begin
            kind = rdse_pkg::CMD_CONVERT;
        end
    end

endmodule

// ===== rtl/rdse_cmd_fifo.sv =====
// Short command queue between the front and back parts.
module rdse_cmd_fifo #(
    parameter int WIDTH = 39
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] store_reg [rdse_pkg::CMD_DEPTH];
    logic [rdse_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [rdse_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [rdse_pkg::CMD_CNT_W-1:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == rdse_pkg::CMD_CNT_W'(rdse_pkg::CMD_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rdse_back.sv =====
// Back part: iterative division by the base, digit buffer, and digit emission with output register.
module rdse_back #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    input  rdse_pkg::cmd_kind_t           cmd_kind,
    input  logic [VALUE_BITS-1:0]         cmd_value,
    input  logic [rdse_pkg::RADIX_W-1:0]  cmd_radix,
    output logic                          cmd_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [rdse_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last,
    output logic                          status
);

    localparam int NCHUNK = (VALUE_BITS + rdse_pkg::DIV_STEP - 1) / rdse_pkg::DIV_STEP;
    localparam int PAD_W = NCHUNK * rdse_pkg::DIV_STEP;
    localparam int SC_W = $clog2(NCHUNK);
    localparam int IDX_W = $clog2(VALUE_BITS);

    rdse_pkg::back_state_t state_reg;
    rdse_pkg::back_state_t state_next;
    rdse_pkg::back_ctrl_t ctrl;

    logic [PAD_W-1:0] div_reg;
    logic [PAD_W-1:0] div_step_q;
    logic [rdse_pkg::RADIX_W-1:0] rem_reg;
    logic [rdse_pkg::RADIX_W-1:0] rem_step;
    logic [rdse_pkg::RADIX_W-1:0] radix_reg;
    logic [SC_W-1:0] step_reg;
    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic last_chunk;
    logic quot_done;

    logic [rdse_pkg::RADIX_W-1:0] mem [VALUE_BITS];
    logic [rdse_pkg::RADIX_W-1:0] mem_q_reg;

    logic rd_valid_reg;
    logic rd_mem_reg;
    logic [rdse_pkg::CHAR_W-1:0] rd_char_reg;
    logic rd_last_reg;
    logic rd_status_reg;
    logic rd_free;
    logic rd_move;

    logic out_valid_reg;
    logic [rdse_pkg::CHAR_W-1:0] out_char_reg;
    logic out_last_reg;
    logic out_status_reg;
    logic out_pop;

    assign last_chunk = (step_reg == SC_W'(NCHUNK - 1));
    assign quot_done = (div_step_q[VALUE_BITS-1:0] == '0)
        || (count_reg == IDX_W'(VALUE_BITS - 1));
    assign out_pop = pop && out_valid_reg;
    assign rd_move = rd_valid_reg && (!out_valid_reg || out_pop);
    assign rd_free = !rd_valid_reg || rd_move;
    assign cmd_pop = ctrl.pop_cmd;

    assign empty = !out_valid_reg;
    assign digit_char = out_char_reg;
    assign last = out_last_reg;
    assign status = out_status_reg;

    // Restoring division, DIV_STEP quotient bits per cycle, most significant first.
    always_comb
    begin : p_div
        logic [rdse_pkg::RADIX_W:0] r;
        logic [rdse_pkg::RADIX_W-1:0] rw;
        logic [PAD_W-1:0] d;
        rw = rem_reg;
        d = div_reg;
        r = '0;
        for (int k = 0; k < rdse_pkg::DIV_STEP; k++)
        begin
            r = {rw, d[PAD_W-1]};
            d = d << 1;
            if (r >= {1'b0, radix_reg})
            begin
                r = r - {1'b0, radix_reg};
                d[0] = 1'b1;
            end
            rw = r[rdse_pkg::RADIX_W-1:0];
        end
        div_step_q = d;
        rem_step = rw;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdse_pkg::BK_IDLE:
            begin
                if (!cmd_empty && (cmd_kind == rdse_pkg::CMD_CONVERT))
                begin
                    state_next = rdse_pkg::BK_DIV;
                end
            end
            rdse_pkg::BK_DIV:
            begin
                if (last_chunk && quot_done)
                begin
                    state_next = rdse_pkg::BK_EMIT;
                end
            end
            rdse_pkg::BK_EMIT:
            begin
                if (rd_free && (ptr_reg == '0))
                begin
                    state_next = rdse_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rdse_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            rdse_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd_kind == rdse_pkg::CMD_CONVERT)
                    begin
                        ctrl.pop_cmd = 1'b1;
                        ctrl.load = 1'b1;
                    end
                    else if (rd_free)
                    begin
                        ctrl.pop_cmd = 1'b1;
                        ctrl.spec_issue = 1'b1;
                    end
                end
            end
            rdse_pkg::BK_DIV:
            begin
                ctrl.div_run = 1'b1;
                ctrl.wr_en = last_chunk;
            end
            rdse_pkg::BK_EMIT:
            begin
                ctrl.rd_issue = rd_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdse_pkg::BK_IDLE;
            step_reg <= '0;
            count_reg <= '0;
            ptr_reg <= '0;
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.load)
            begin
                step_reg <= '0;
                count_reg <= '0;
            end
            else if (ctrl.div_run)
            begin
                step_reg <= last_chunk ? '0 : step_reg + 1'b1;
                if (ctrl.wr_en && !quot_done)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (ctrl.wr_en && quot_done)
            begin
                ptr_reg <= count_reg;
            end
            else if (ctrl.rd_issue)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
            if (ctrl.rd_issue || ctrl.spec_issue)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            radix_reg <= cmd_radix;
            div_reg <= PAD_W'(cmd_value);
            rem_reg <= '0;
        end
        else if (ctrl.div_run)
        begin
            div_reg <= div_step_q;
            rem_reg <= last_chunk ? '0 : rem_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[count_reg] <= rem_step;
        end
        if (ctrl.rd_issue)
        begin
            mem_q_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.spec_issue)
        begin
            rd_mem_reg <= 1'b0;
            rd_last_reg <= 1'b1;
            if (cmd_kind == rdse_pkg::CMD_INVALID)
            begin
                rd_char_reg <= '0;
                rd_status_reg <= 1'b1;
            end
            else
            begin
                rd_char_reg <= rdse_pkg::CHAR_ZERO;
                rd_status_reg <= 1'b0;
            end
        end
        else if (ctrl.rd_issue)
        begin
            rd_mem_reg <= 1'b1;
            rd_last_reg <= (ptr_reg == '0);
            rd_status_reg <= 1'b0;
        end
        if (rd_move)
        begin
            out_char_reg <= rd_mem_reg ? rdse_pkg::digit_to_ascii(mem_q_reg) : rd_char_reg;
            out_last_reg <= rd_last_reg;
            out_status_reg <= rd_status_reg;
        end
    end

endmodule

// ===== rtl/radix_digit_string_emitter_unit.sv =====
// Top level of the radix digit string emitter: front classifier, command queue and back converter.
// Each accepted beat carries a value and a base; the block returns the value's digits in that
// base as ASCII characters, most significant first, one beat per digit with last set on the
// final one. A base outside 2 to 36 returns a single beat with status set and a zero character,
// and a zero value returns the single digit '0'. Up to two commands wait in a queue in front of
// the converter. A conversion divides the value by the base once per digit in the divider,
// which retires four quotient bits a cycle, then emits one digit per cycle while the consumer
// keeps popping, from the digit buffer through a two-stage read and output path.
// Invalid-base and zero commands pass through the read register and then the output register.
module radix_digit_string_emitter_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [VALUE_BITS-1:0]         value,
    input  logic [rdse_pkg::RADIX_W-1:0]  radix,
    output logic                          empty,
    input  logic                          pop,
    output logic [rdse_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last,
    output logic                          status
);

    localparam int CMD_W = rdse_pkg::KIND_W + rdse_pkg::RADIX_W + VALUE_BITS;

    rdse_pkg::cmd_kind_t in_kind;
    logic [CMD_W-1:0] cmd_wdata;
    logic [CMD_W-1:0] cmd_rdata;
    logic cmd_empty;
    logic cmd_pop;

    rdse_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .value (value),
        .radix (radix),
        .kind  (in_kind)
    );

    assign cmd_wdata = {in_kind, radix, value};

    rdse_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_wdata),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    rdse_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_kind   (rdse_pkg::cmd_kind_t'(cmd_rdata[CMD_W-1 -: rdse_pkg::KIND_W])),
        .cmd_value  (cmd_rdata[VALUE_BITS-1:0]),
        .cmd_radix  (cmd_rdata[VALUE_BITS +: rdse_pkg::RADIX_W]),
        .cmd_pop    (cmd_pop),
        .pop        (pop),
        .empty      (empty),
        .digit_char (digit_char),
        .last       (last),
        .status     (status)
    );

    a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (last && (digit_char == '0)))
        else $error("invalid-base beat must be a single last beat with a zero character");

    a_digit_is_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !status) |->
            (((digit_char >= 7'd48) && (digit_char <= 7'd57))
            || ((digit_char >= 7'd65) && (digit_char <= 7'd90))))
        else $error("digit beat carries a character outside 0-9 and A-Z");

    a_queue_pop_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("back part took a command from an empty queue");

endmodule
